// ===== rtl/modular_range_sum_tree_core_assert.svh =====
// assertion macros for the modular range sum tree core
// expects signals clk and rst_n in the scope where a macro is used
`ifndef MODULAR_RANGE_SUM_TREE_CORE_ASSERT_SVH
`define MODULAR_RANGE_SUM_TREE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MRST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in modular_range_sum_tree_core");

// next-cycle implication, disabled during reset
`define MRST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in modular_range_sum_tree_core");

`endif

// ===== rtl/mrst_pkg.sv =====
// shared types and constants for the modular range sum tree
// no dependencies; used by the channel interfaces and the core
package mrst_pkg;

    localparam int DEFAULT_LEAVES = 1024;

    localparam int CMD_W = 2;
    localparam int IDX_W = 11;
    localparam int VAL_W = 31;
    localparam int MOD_W = 32;
    localparam int STS_W = 2;

    localparam logic [MOD_W-1:0] DEFAULT_MODULUS = 32'd998244353;
    localparam logic [MOD_W-1:0] MOD_CAP         = 32'h8000_0000;

    localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_BAD_POS = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY   = 2'd2;
    localparam logic [STS_W-1:0] STS_BAD_VAL = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_BUILD_RD,
        S_BUILD_WR,
        S_LEAF,
        S_UP_RD,
        S_UP_WR,
        S_Q_RD,
        S_Q_LO,
        S_Q_HI,
        S_DONE
    } state_t;

endpackage

// ===== rtl/mrst_if.sv =====
// valid/ready channel interfaces for the modular range sum tree
// depends on mrst_pkg for field widths
interface mrst_req_if;
    logic                         valid;
    logic                         ready;
    logic [mrst_pkg::CMD_W-1:0]   command;
    logic [mrst_pkg::IDX_W-1:0]   left_index;
    logic [mrst_pkg::IDX_W-1:0]   right_index;
    logic [mrst_pkg::VAL_W-1:0]   value;
    logic [mrst_pkg::IDX_W-1:0]   leaf_count;

    modport source (output valid, command, left_index, right_index, value, leaf_count,
                    input ready);
    modport sink (input valid, command, left_index, right_index, value, leaf_count,
                  output ready);
endinterface

interface mrst_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [mrst_pkg::VAL_W-1:0]   sum;
    logic [mrst_pkg::STS_W-1:0]   status;

    modport source (output valid, sum, status, input ready);
    modport sink (input valid, sum, status, output ready);
endinterface

interface mrst_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mrst_pkg::MOD_W-1:0]   modulus;

    modport source (output valid, modulus, input ready);
    modport sink (input valid, modulus, output ready);
endinterface

// ===== rtl/modular_range_sum_tree_core.sv =====
// Segment tree of residues with point assign and modular range sums.
// Usage:
//   cfg : write channel for the modulus; always ready, taken at the next good init.
//   req : one request per command (init and fill, assign leaf, range query).
//   rsp : one response per request with sum and status.
// Steps, all through one shared modular adder and a two-read, one-write node memory:
//   query  : a first read, then one tree level at a time, lo side then hi side
//   assign : write the leaf, then per level read both children and write the parent
//   init   : one leaf write per cycle, then a read and a write per inner node
//   errors and the unused command: straight to the response
// Throughput is one request at a time; req.ready is high only while no request is in
// work. A finished response sits in an output register, so a new request may start
// while rsp is stalled; it then waits at its end until the register frees up.
// Reset: modulus 998244353, zero leaves in use (assign and query report a bad
// position until an init), node memory holds no defined data until an init.
// Depends on mrst_pkg, mrst_if and the assertion macro header.
`include "modular_range_sum_tree_core_assert.svh"

module modular_range_sum_tree_core #(
    parameter int LEAVES = mrst_pkg::DEFAULT_LEAVES
) (
    input  logic      clk,
    input  logic      rst_n,
    mrst_cfg_if.sink  cfg,
    mrst_req_if.sink  req,
    mrst_rsp_if.source rsp
);

    localparam int AW = $clog2(2 * LEAVES);
    localparam int NW = AW + 1;
    localparam int VW = mrst_pkg::VAL_W;
    localparam int MW = mrst_pkg::MOD_W;
    localparam int IW = mrst_pkg::IDX_W;
    localparam logic [NW-1:0] LEAVES_N  = NW'(LEAVES);
    localparam logic [NW-1:0] LAST_NODE = NW'(2 * LEAVES - 1);
    localparam logic [NW-1:0] ONE_N     = NW'(1);
    localparam logic [MW-1:0] LEAVES_U  = MW'(LEAVES);

    mrst_pkg::state_t state_reg, state_next;

    logic [MW-1:0]                mod_reg, mod_next;
    logic [MW-1:0]                active_mod_reg, active_mod_next;
    logic [IW-1:0]                leaves_in_use_reg, leaves_in_use_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    logic [NW-1:0]                node_reg, node_next;
    logic [NW-1:0]                lo_reg, lo_next;
    logic [NW-1:0]                hi_reg, hi_next;
    logic [VW-1:0]                sum_reg, sum_next;
    logic [mrst_pkg::STS_W-1:0]   sts_reg, sts_next;
    logic [VW-1:0]                fill_val_reg, fill_val_next;
    logic [VW-1:0]                rsp_sum_reg, rsp_sum_next;
    logic [mrst_pkg::STS_W-1:0]   rsp_status_reg, rsp_status_next;

    // node memory: two read ports, one write port, registered reads
    logic [VW-1:0]                node_mem [2*LEAVES];
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [VW-1:0]                mem_wdata;
    logic [AW-1:0]                mem_raddr_a, mem_raddr_b;
    logic [VW-1:0]                mem_qa, mem_qb;

    // shared modular adder
    logic [VW-1:0]                op_a, op_b;
    logic [MW-1:0]                add_raw, add_red;
    logic [VW-1:0]                add_out;

    logic [MW-1:0]                mod_clamped;
    logic [NW-1:0]                fill_pos, lo_adv, hi_adv, hi_adv_m1, hi_m1;
    logic                         req_fire;

    assign add_raw = {1'b0, op_a} + {1'b0, op_b};
    assign add_red = (add_raw >= active_mod_reg) ? add_raw - active_mod_reg : add_raw;
    assign add_out = add_red[VW-1:0];

    assign mod_clamped = (mod_reg == '0 || mod_reg > mrst_pkg::MOD_CAP)
                         ? mrst_pkg::MOD_CAP : mod_reg;

    assign fill_pos  = node_reg - LEAVES_N;
    assign lo_adv    = (lo_reg + NW'(lo_reg[0])) >> 1;
    assign hi_adv    = hi_reg >> 1;
    assign hi_adv_m1 = hi_adv - ONE_N;
    assign hi_m1     = hi_reg - ONE_N;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == mrst_pkg::S_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.sum    = rsp_sum_reg;
    assign rsp.status = rsp_status_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        mem_qa <= node_mem[mem_raddr_a];
        mem_qb <= node_mem[mem_raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= mrst_pkg::S_IDLE;
            mod_reg           <= mrst_pkg::DEFAULT_MODULUS;
            active_mod_reg    <= mrst_pkg::DEFAULT_MODULUS;
            leaves_in_use_reg <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            mod_reg           <= mod_next;
            active_mod_reg    <= active_mod_next;
            leaves_in_use_reg <= leaves_in_use_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        sum_reg        <= sum_next;
        sts_reg        <= sts_next;
        fill_val_reg   <= fill_val_next;
        rsp_sum_reg    <= rsp_sum_next;
        rsp_status_reg <= rsp_status_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        mod_next           = mod_reg;
        active_mod_next    = active_mod_reg;
        leaves_in_use_next = leaves_in_use_reg;
        rsp_valid_next     = rsp_valid_reg;
        node_next          = node_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        sum_next           = sum_reg;
        sts_next           = sts_reg;
        fill_val_next      = fill_val_reg;
        rsp_sum_next       = rsp_sum_reg;
        rsp_status_next    = rsp_status_reg;

        mem_we      = 1'b0;
        mem_waddr   = node_reg[AW-1:0];
        mem_wdata   = add_out;
        mem_raddr_a = lo_reg[AW-1:0];
        mem_raddr_b = hi_m1[AW-1:0];
        op_a        = mem_qa;
        op_b        = mem_qb;

        if (cfg.valid && cfg.ready)
        begin
            mod_next = cfg.modulus;
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            mrst_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    sum_next   = '0;
                    sts_next   = mrst_pkg::STS_OK;
                    state_next = mrst_pkg::S_DONE;
                    unique case (req.command)
                        mrst_pkg::CMD_INIT:
                        begin
                            if (req.leaf_count == '0 || MW'(req.leaf_count) > LEAVES_U)
                            begin
                                sts_next = mrst_pkg::STS_BAD_POS;
                            end
                            else if (MW'(req.value) >= mod_clamped)
                            begin
                                sts_next = mrst_pkg::STS_BAD_VAL;
                            end
                            else
                            begin
                                active_mod_next    = mod_clamped;
                                leaves_in_use_next = req.leaf_count;
                                fill_val_next      = req.value;
                                node_next          = LEAVES_N;
                                state_next         = mrst_pkg::S_FILL;
                            end
                        end
                        mrst_pkg::CMD_ASSIGN:
                        begin
                            if (req.left_index == '0 || req.left_index > leaves_in_use_reg)
                            begin
                                sts_next = mrst_pkg::STS_BAD_POS;
                            end
                            else if (MW'(req.value) >= active_mod_reg)
                            begin
                                sts_next = mrst_pkg::STS_BAD_VAL;
                            end
                            else
                            begin
                                fill_val_next = req.value;
                                node_next     = LEAVES_N + NW'(req.left_index) - ONE_N;
                                state_next    = mrst_pkg::S_LEAF;
                            end
                        end
                        mrst_pkg::CMD_QUERY:
                        begin
                            if (req.left_index == '0 || req.right_index > leaves_in_use_reg)
                            begin
                                sts_next = mrst_pkg::STS_BAD_POS;
                            end
                            else if (req.left_index > req.right_index)
                            begin
                                sts_next = mrst_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                lo_next    = LEAVES_N + NW'(req.left_index) - ONE_N;
                                hi_next    = LEAVES_N + NW'(req.right_index);
                                state_next = mrst_pkg::S_Q_RD;
                            end
                        end
                        mrst_pkg::CMD_NOP:
                        begin
                            sts_next = mrst_pkg::STS_OK;
                        end
                    endcase
                end
            end

            // leaves below the count get the fill value, the rest zero
            mrst_pkg::S_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = (fill_pos < NW'(leaves_in_use_reg)) ? fill_val_reg : '0;
                if (node_reg == LAST_NODE)
                begin
                    node_next  = LEAVES_N - ONE_N;
                    state_next = mrst_pkg::S_BUILD_RD;
                end
                else
                begin
                    node_next = node_reg + ONE_N;
                end
            end

            mrst_pkg::S_BUILD_RD:
            begin
                mem_raddr_a = {node_reg[AW-2:0], 1'b0};
                mem_raddr_b = {node_reg[AW-2:0], 1'b1};
                state_next  = mrst_pkg::S_BUILD_WR;
            end

            mrst_pkg::S_BUILD_WR:
            begin
                mem_we = 1'b1;
                if (node_reg == ONE_N)
                begin
                    state_next = mrst_pkg::S_DONE;
                end
                else
                begin
                    node_next  = node_reg - ONE_N;
                    state_next = mrst_pkg::S_BUILD_RD;
                end
            end

            mrst_pkg::S_LEAF:
            begin
                mem_we     = 1'b1;
                mem_wdata  = fill_val_reg;
                state_next = mrst_pkg::S_UP_RD;
            end

            // node_reg is a child here; read it and its sibling
            mrst_pkg::S_UP_RD:
            begin
                mem_raddr_a = {node_reg[AW-1:1], 1'b0};
                mem_raddr_b = {node_reg[AW-1:1], 1'b1};
                node_next   = node_reg >> 1;
                state_next  = mrst_pkg::S_UP_WR;
            end

            mrst_pkg::S_UP_WR:
            begin
                mem_we = 1'b1;
                if (node_reg == ONE_N)
                begin
                    state_next = mrst_pkg::S_DONE;
                end
                else
                begin
                    state_next = mrst_pkg::S_UP_RD;
                end
            end

            mrst_pkg::S_Q_RD:
            begin
                state_next = mrst_pkg::S_Q_LO;
            end

            mrst_pkg::S_Q_LO:
            begin
                op_a = sum_reg;
                op_b = mem_qa;
                if (lo_reg[0])
                begin
                    sum_next = add_out;
                end
                state_next = mrst_pkg::S_Q_HI;
            end

            // finish the level and prefetch the next pair of boundary nodes
            mrst_pkg::S_Q_HI:
            begin
                op_a = sum_reg;
                op_b = mem_qb;
                if (hi_reg[0])
                begin
                    sum_next = add_out;
                end
                lo_next     = lo_adv;
                hi_next     = hi_adv;
                mem_raddr_a = lo_adv[AW-1:0];
                mem_raddr_b = hi_adv_m1[AW-1:0];
                if (lo_adv < hi_adv)
                begin
                    state_next = mrst_pkg::S_Q_LO;
                end
                else
                begin
                    state_next = mrst_pkg::S_DONE;
                end
            end

            mrst_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_sum_next    = sum_reg;
                    rsp_status_next = sts_reg;
                    state_next      = mrst_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mrst_pkg::S_IDLE;
            end
        endcase
    end

    `MRST_ASSERT_NEXT(a_req_leaves_idle, req_fire, state_reg != mrst_pkg::S_IDLE)
    `MRST_ASSERT_NOW(a_query_window, (state_reg == mrst_pkg::S_Q_LO || state_reg == mrst_pkg::S_Q_HI), lo_reg < hi_reg)
    `MRST_ASSERT_NOW(a_no_root_parent_write, mem_we, mem_waddr != '0)
    `MRST_ASSERT_NOW(a_mod_in_range, 1'b1, active_mod_reg != '0 && active_mod_reg <= mrst_pkg::MOD_CAP)
    `MRST_ASSERT_NOW(a_err_sum_zero, rsp_valid_reg && rsp_status_reg != mrst_pkg::STS_OK, rsp_sum_reg == '0)

endmodule

// ===== dv/modular_range_sum_tree_core_tb.sv =====
`timescale 1ns / 100ps
// testbench for modular_range_sum_tree_core: directed and random tree commands, each
// response checked in order against a segment tree kept in the bench
// depends on mrst_pkg, mrst_if and the core from rtl
module modular_range_sum_tree_core_tb;

    localparam int LEAVES      = mrst_pkg::DEFAULT_LEAVES;
    localparam int CLK_PERIOD  = 10;
    localparam int STALL_LIMIT = 16000;
    localparam int TAIL_CYCLES = 40;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 118;

    typedef struct packed {
        logic [mrst_pkg::CMD_W-1:0] command;
        logic [mrst_pkg::IDX_W-1:0] left_index;
        logic [mrst_pkg::IDX_W-1:0] right_index;
        logic [mrst_pkg::VAL_W-1:0] value;
        logic [mrst_pkg::IDX_W-1:0] leaf_count;
    } tree_req_t;

    typedef struct packed {
        logic [mrst_pkg::VAL_W-1:0] sum;
        logic [mrst_pkg::STS_W-1:0] status;
    } tree_rsp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mrst_cfg_if cfg_ch();
    mrst_req_if req_ch();
    mrst_rsp_if rsp_ch();

    modular_range_sum_tree_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tree_req_t cmd_q[$];
    tree_rsp_t sum_status_q[$];
    tree_req_t cur_req;

    // bench copy of the tree
    logic [mrst_pkg::MOD_W-1:0] cfg_modulus;
    logic [mrst_pkg::MOD_W-1:0] tree_mod = mrst_pkg::DEFAULT_MODULUS;
    logic [mrst_pkg::VAL_W-1:0] tree_node [0:2*LEAVES-1];
    logic [mrst_pkg::IDX_W-1:0] leaves_used = '0;

    // what the stimulus generator believes is in effect
    logic [mrst_pkg::MOD_W-1:0] gen_mod;
    int                         gen_leaves;

    // a request popped from the queue and not yet accepted
    logic req_busy = 1'b0;

    int send_gap_max;
    int recv_gap_max;
    int send_gap;
    int recv_wait;
    int idle_cycles = 0;
    int error_count = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [mrst_pkg::MOD_W-1:0] clamp_modulus(
        input logic [mrst_pkg::MOD_W-1:0] m);
        if (m == '0 || m > mrst_pkg::MOD_CAP)
            return mrst_pkg::MOD_CAP;
        return m;
    endfunction

    function automatic logic [mrst_pkg::VAL_W-1:0] mod_add(
        input logic [mrst_pkg::VAL_W-1:0] a,
        input logic [mrst_pkg::VAL_W-1:0] b,
        input logic [mrst_pkg::MOD_W-1:0] m);
        logic [mrst_pkg::MOD_W:0] s;
        s = {2'b00, a} + {2'b00, b};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[mrst_pkg::VAL_W-1:0];
    endfunction

    // applies one accepted command to the tree and queues the response it owes
    task automatic tree_apply(input tree_req_t r);
        tree_rsp_t                  e;
        logic [mrst_pkg::MOD_W-1:0] m;
        int                         i;
        int                         node;
        int                         lo;
        int                         hi;
        e.sum    = '0;
        e.status = mrst_pkg::STS_OK;
        case (r.command)
            mrst_pkg::CMD_INIT:
            begin
                m = clamp_modulus(cfg_modulus);
                if (r.leaf_count == 0 || r.leaf_count > LEAVES)
                    e.status = mrst_pkg::STS_BAD_POS;
                else if ({1'b0, r.value} >= m)
                    e.status = mrst_pkg::STS_BAD_VAL;
                else
                begin
                    tree_mod    = m;
                    leaves_used = r.leaf_count;
                    for (i = 0; i < LEAVES; i++)
                        tree_node[LEAVES + i] = (i < r.leaf_count) ? r.value : '0;
                    for (i = LEAVES - 1; i >= 1; i--)
                        tree_node[i] = mod_add(tree_node[2*i], tree_node[2*i+1], tree_mod);
                end
            end
            mrst_pkg::CMD_ASSIGN:
            begin
                if (r.left_index == 0 || r.left_index > leaves_used)
                    e.status = mrst_pkg::STS_BAD_POS;
                else if ({1'b0, r.value} >= tree_mod)
                    e.status = mrst_pkg::STS_BAD_VAL;
                else
                begin
                    node = LEAVES + int'(r.left_index) - 1;
                    tree_node[node] = r.value;
                    while (node > 1)
                    begin
                        node = node >> 1;
                        tree_node[node] = mod_add(tree_node[2*node], tree_node[2*node+1],
                                                  tree_mod);
                    end
                end
            end
            mrst_pkg::CMD_QUERY:
            begin
                if (r.left_index == 0 || r.right_index > leaves_used)
                    e.status = mrst_pkg::STS_BAD_POS;
                else if (r.left_index > r.right_index)
                    e.status = mrst_pkg::STS_EMPTY;
                else
                begin
                    lo = LEAVES + int'(r.left_index) - 1;
                    hi = LEAVES + int'(r.right_index);
                    while (lo < hi)
                    begin
                        if (lo[0])
                        begin
                            e.sum = mod_add(e.sum, tree_node[lo], tree_mod);
                            lo++;
                        end
                        if (hi[0])
                        begin
                            hi--;
                            e.sum = mod_add(e.sum, tree_node[hi], tree_mod);
                        end
                        lo = lo >> 1;
                        hi = hi >> 1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        sum_status_q.push_back(e);
    endtask

    // request driver: one command per accepted request, random gap after each
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        int gap;
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.command     <= mrst_pkg::CMD_NOP;
            req_ch.left_index  <= '0;
            req_ch.right_index <= '0;
            req_ch.value       <= '0;
            req_ch.leaf_count  <= '0;
            send_gap           <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            gap = send_gap;
            if (req_ch.valid)
            begin
                tree_apply(cur_req);
                req_busy = 1'b0;
                gap = $urandom_range(send_gap_max, 0);
            end
            if (gap == 0 && cmd_q.size() != 0)
            begin
                cur_req  = cmd_q.pop_front();
                req_busy = 1'b1;
                req_ch.valid       <= 1'b1;
                req_ch.command     <= cur_req.command;
                req_ch.left_index  <= cur_req.left_index;
                req_ch.right_index <= cur_req.right_index;
                req_ch.value       <= cur_req.value;
                req_ch.leaf_count  <= cur_req.leaf_count;
                send_gap           <= 0;
            end
            else
            begin
                req_ch.valid <= 1'b0;
                send_gap     <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    // response monitor: ready may drop for a random number of cycles after each response
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        tree_rsp_t want;
        int        stall;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b1;
            recv_wait    <= 0;
        end
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (sum_status_q.size() == 0)
            begin
                $display("%0t: response with nothing outstanding: sum %0d status %0d",
                         $time, rsp_ch.sum, rsp_ch.status);
                error_count++;
            end
            else
            begin
                want = sum_status_q.pop_front();
                if (rsp_ch.sum !== want.sum)
                begin
                    $display("%0t: sum mismatch: expected %0d, actual %0d",
                             $time, want.sum, rsp_ch.sum);
                    error_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp_ch.status);
                    error_count++;
                end
            end
            stall = $urandom_range(recv_gap_max, 0);
            rsp_ch.ready <= (stall == 0);
            recv_wait    <= stall;
        end
        else if (rsp_ch.valid && !rsp_ch.ready)
        begin
            if (recv_wait <= 1)
            begin
                rsp_ch.ready <= 1'b1;
                recv_wait    <= 0;
            end
            else
                recv_wait <= recv_wait - 1;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("FAIL modular_range_sum_tree_core");
            $finish;
        end
    end

    task automatic write_modulus(input logic [mrst_pkg::MOD_W-1:0] m);
        @(posedge clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.modulus <= m;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_modulus = m;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_cmd(input logic [mrst_pkg::CMD_W-1:0] c, input int l, input int r,
                            input logic [mrst_pkg::VAL_W-1:0] v, input int n);
        tree_req_t q;
        q.command     = c;
        q.left_index  = mrst_pkg::IDX_W'(l);
        q.right_index = mrst_pkg::IDX_W'(r);
        q.value       = v;
        q.leaf_count  = mrst_pkg::IDX_W'(n);
        cmd_q.push_back(q);
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || req_busy || sum_status_q.size() != 0)
            @(posedge clk);
    endtask

    // mostly in range, with the top residue, zero and values not below the modulus mixed in
    function automatic logic [mrst_pkg::VAL_W-1:0] pick_value(
        input logic [mrst_pkg::MOD_W-1:0] m);
        int unsigned roll;
        roll = $urandom_range(19, 0);
        if (roll == 0)
            return '0;
        if (roll < 3)
            return mrst_pkg::VAL_W'(m - 1);
        if (roll == 3 && m < mrst_pkg::MOD_CAP)
            return mrst_pkg::VAL_W'($urandom_range(32'h7FFF_FFFF, m));
        return mrst_pkg::VAL_W'($urandom_range(m - 1, 0));
    endfunction

    task automatic push_good_init();
        int unsigned roll;
        int          n;
        roll = $urandom_range(19, 0);
        if (roll < 12)
            n = $urandom_range(16, 1);
        else if (roll < 17)
            n = $urandom_range(LEAVES - 1, 17);
        else
            n = LEAVES;
        gen_mod    = clamp_modulus(cfg_modulus);
        gen_leaves = n;
        push_cmd(mrst_pkg::CMD_INIT, $urandom_range(2047, 0), $urandom_range(2047, 0),
                 mrst_pkg::VAL_W'($urandom_range(gen_mod - 1, 0)), n);
    endtask

    initial
    begin
        logic [mrst_pkg::MOD_W-1:0] mod_list [RAND_PHASES];
        logic [mrst_pkg::MOD_W-1:0] m;
        logic [mrst_pkg::VAL_W-1:0] v;
        logic [mrst_pkg::CMD_W-1:0] c;
        int unsigned                roll;
        int                         l;
        int                         r;
        int                         n;

        cfg_ch.valid       = 1'b0;
        cfg_ch.modulus     = '0;
        cfg_modulus        = mrst_pkg::DEFAULT_MODULUS;
        gen_leaves         = 0;
        send_gap_max       = 0;
        recv_gap_max       = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any init, bad init forms, full tree, bounds
        push_cmd(mrst_pkg::CMD_ASSIGN, 1, 0, 5, 0);
        push_cmd(mrst_pkg::CMD_QUERY, 1, 1, 0, 0);
        push_cmd(mrst_pkg::CMD_NOP, 2047, 2047, 31'h7FFF_FFFF, 2047);
        push_cmd(mrst_pkg::CMD_INIT, 0, 0, 1, 0);
        push_cmd(mrst_pkg::CMD_INIT, 0, 0, 1, LEAVES + 1);
        push_cmd(mrst_pkg::CMD_INIT, 0, 0, 31'h7FFF_FFFF, 2047);
        push_cmd(mrst_pkg::CMD_INIT, 0, 0, mrst_pkg::VAL_W'(mrst_pkg::DEFAULT_MODULUS),
                 LEAVES);
        push_cmd(mrst_pkg::CMD_INIT, 0, 0, mrst_pkg::VAL_W'(mrst_pkg::DEFAULT_MODULUS - 1),
                 LEAVES);
        push_cmd(mrst_pkg::CMD_QUERY, 1, LEAVES, 0, 0);
        push_cmd(mrst_pkg::CMD_QUERY, 0, 5, 0, 0);
        push_cmd(mrst_pkg::CMD_QUERY, 1, LEAVES + 1, 0, 0);
        push_cmd(mrst_pkg::CMD_QUERY, 6, 5, 0, 0);
        push_cmd(mrst_pkg::CMD_QUERY, 2047, 2047, 31'h7FFF_FFFF, 2047);
        push_cmd(mrst_pkg::CMD_ASSIGN, 0, 0, mrst_pkg::VAL_W'(mrst_pkg::DEFAULT_MODULUS), 0);
        push_cmd(mrst_pkg::CMD_ASSIGN, LEAVES + 1, 0, 0, 0);
        push_cmd(mrst_pkg::CMD_ASSIGN, 3, 0, mrst_pkg::VAL_W'(mrst_pkg::DEFAULT_MODULUS), 0);
        push_cmd(mrst_pkg::CMD_ASSIGN, LEAVES, 0, 0, 0);
        push_cmd(mrst_pkg::CMD_ASSIGN, 1, 0, mrst_pkg::VAL_W'(mrst_pkg::DEFAULT_MODULUS - 1),
                 0);
        push_cmd(mrst_pkg::CMD_QUERY, LEAVES, LEAVES, 0, 0);
        push_cmd(mrst_pkg::CMD_QUERY, 1, LEAVES, 0, 0);
        wait_drained();

        // a new modulus only counts from the next good init
        send_gap_max = 18;
        recv_gap_max = 18;
        write_modulus(32'd7);
        push_cmd(mrst_pkg::CMD_QUERY, 1, LEAVES, 0, 0);
        push_cmd(mrst_pkg::CMD_ASSIGN, 2, 0, 100, 0);
        push_cmd(mrst_pkg::CMD_INIT, 0, 0, 6, 5);
        push_cmd(mrst_pkg::CMD_ASSIGN, 3, 0, 7, 0);
        push_cmd(mrst_pkg::CMD_ASSIGN, 5, 0, 6, 0);
        push_cmd(mrst_pkg::CMD_QUERY, 1, 5, 0, 0);
        push_cmd(mrst_pkg::CMD_QUERY, 6, 6, 0, 0);
        wait_drained();

        mod_list = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd2, 32'h8000_0001,
                     mrst_pkg::DEFAULT_MODULUS, $urandom_range(1000, 3), $urandom,
                     32'h7FFF_FFFF, $urandom_range(32'h8000_0000, 32'h4000_0000), 32'd7};

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p % 4)
                0:       begin send_gap_max = 0;  recv_gap_max = 0;  end
                1:       begin send_gap_max = 18; recv_gap_max = 18; end
                2:       begin send_gap_max = 18; recv_gap_max = 0;  end
                default: begin send_gap_max = 0;  recv_gap_max = 18; end
            endcase
            write_modulus(mod_list[p]);
            push_good_init();
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(99, 0);
                if (roll < 3)
                    push_good_init();
                else if (roll < 45)
                begin
                    l = $urandom_range(gen_leaves, 1);
                    if (roll < 10)
                        r = l;
                    else if (roll < 14)
                    begin
                        l = 1;
                        r = gen_leaves;
                    end
                    else
                        r = $urandom_range(gen_leaves, l);
                    push_cmd(mrst_pkg::CMD_QUERY, l, r, mrst_pkg::VAL_W'($urandom),
                             $urandom_range(2047, 0));
                end
                else if (roll < 82)
                    push_cmd(mrst_pkg::CMD_ASSIGN, $urandom_range(gen_leaves, 1),
                             $urandom_range(2047, 0), pick_value(gen_mod),
                             $urandom_range(2047, 0));
                else if (roll < 88)
                begin
                    // broken ranges and positions
                    case ($urandom_range(3, 0))
                        0:
                        begin
                            l = $urandom_range(gen_leaves + 1, 2);
                            r = $urandom_range(l - 1, 1);
                            push_cmd(mrst_pkg::CMD_QUERY, l, r, 0, 0);
                        end
                        1:
                        begin
                            r = $urandom_range(2047, gen_leaves + 1);
                            push_cmd(mrst_pkg::CMD_QUERY, $urandom_range(r, 1), r, 0, 0);
                        end
                        2:
                            push_cmd(mrst_pkg::CMD_QUERY, 0, $urandom_range(gen_leaves, 0),
                                     0, 0);
                        default:
                            push_cmd(mrst_pkg::CMD_ASSIGN,
                                     $urandom_range(2047, gen_leaves + 1), 0,
                                     pick_value(gen_mod), 0);
                    endcase
                end
                else
                begin
                    c = mrst_pkg::CMD_W'($urandom_range(3, 0));
                    v = mrst_pkg::VAL_W'($urandom);
                    n = $urandom_range(2047, 0);
                    m = clamp_modulus(cfg_modulus);
                    if (c == mrst_pkg::CMD_INIT && n >= 1 && n <= LEAVES && {1'b0, v} < m)
                    begin
                        gen_leaves = n;
                        gen_mod    = m;
                    end
                    push_cmd(c, $urandom_range(2047, 0), $urandom_range(2047, 0), v, n);
                end
            end
            // sender holds back here until every response is in
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && sum_status_q.size() == 0)
            $display("PASS modular_range_sum_tree_core");
        else
            $display("FAIL modular_range_sum_tree_core");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mrst_pkg.sv
rtl/mrst_if.sv
rtl/modular_range_sum_tree_core.sv
dv/modular_range_sum_tree_core_tb.sv
